### design/refcounted_lru_slot_cache_macros.svh
// Assertion macros shared by the checker of the slot cache.
`ifndef REFCOUNTED_LRU_SLOT_CACHE_MACROS_SVH
`define REFCOUNTED_LRU_SLOT_CACHE_MACROS_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define RLSC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define RLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/rlsc_pkg.sv
// Shared types and constants of the reference counted slot cache.
`timescale 1ns / 1ps
package rlsc_pkg;

   localparam int SLOTS_DEF = 8;

   localparam int OP_W     = 2;
   localparam int TAG_W    = 64;
   localparam int KIND_W   = 2;
   localparam int SEL_W    = 4;
   localparam int STATUS_W = 2;
   localparam int REF_W    = 16;
   localparam int TICK_W   = 32;
   localparam int CNT_W    = 32;

   // Request operations
   localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
   localparam logic [OP_W-1:0] OP_USE     = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_KEY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic decode;
      logic scan;
      logic update;
   } rlsc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_scan;
      logic scan_last;
   } rlsc_sts_type;

endpackage

### design/rlsc_ctrl.sv
// Sequencer of the slot cache: decode, optional victim scan, update.
`timescale 1ns / 1ps
module rlsc_ctrl
   import rlsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  rlsc_sts_type sts,
   output rlsc_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_UPDATE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Advance through the request phases
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = sts.need_scan ? S_SCAN : S_UPDATE;
         end
         S_SCAN: begin
            if (sts.scan_last) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Drive commands from the current phase
   always_comb begin
      cmd.load   = (state_ff == S_IDLE) && start;
      cmd.decode = (state_ff == S_DECODE);
      cmd.scan   = (state_ff == S_SCAN);
      cmd.update = (state_ff == S_UPDATE);
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### design/rlsc_datapath.sv
// Slot table, lookup, victim scan, update and response registers.
`timescale 1ns / 1ps
module rlsc_datapath
   import rlsc_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  rlsc_cmd_type        cmd,
   output rlsc_sts_type        sts,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic                req_key_present,
   input  logic [TAG_W-1:0]    req_key_tag,
   input  logic [KIND_W-1:0]   req_kind_code,
   input  logic [SEL_W-1:0]    req_slot_select,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SEL_W-1:0]    rsp_slot_number,
   output logic                rsp_hit,
   output logic [KIND_W-1:0]   rsp_slot_kind,
   output logic [CNT_W-1:0]    rsp_slot_uses,
   output logic [CNT_W-1:0]    rsp_hit_total,
   output logic [CNT_W-1:0]    rsp_miss_total
);

   localparam int SLOT_W = $clog2(SLOTS);

   // Captured request
   logic [OP_W-1:0]   op_ff;
   logic              key_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [SEL_W-1:0]  sel_ff;

   // Slot table
   logic [SLOTS-1:0]  occ_ff;
   logic [TAG_W-1:0]  etag_ff  [SLOTS];
   logic [KIND_W-1:0] ekind_ff [SLOTS];
   logic [REF_W-1:0]  eref_ff  [SLOTS];
   logic [TICK_W-1:0] elast_ff [SLOTS];
   logic [CNT_W-1:0]  euses_ff [SLOTS];

   logic [TICK_W-1:0] tick_ff;
   logic [CNT_W-1:0]  hits_ff;
   logic [CNT_W-1:0]  misses_ff;

   // Lookup results
   logic              hit_ff;
   logic [SLOT_W-1:0] hit_idx_ff;
   logic              free_any_ff;
   logic [SLOT_W-1:0] free_idx_ff;

   // Victim scan
   logic [SLOT_W-1:0] scan_idx_ff;
   logic [SLOT_W-1:0] best_idx_ff;
   logic [TICK_W-1:0] best_tick_ff;

   logic [SLOTS-1:0]  match_vec;
   logic [SLOT_W-1:0] match_idx;
   logic [SLOT_W-1:0] free_idx;
   logic              is_acq;
   logic              is_sel_op;
   logic              in_range;
   logic [SLOT_W-1:0] target;
   logic [SLOT_W-1:0] rd_idx;
   logic              rd_occ;
   logic [KIND_W-1:0] rd_kind;
   logic [REF_W-1:0]  rd_ref;
   logic [TICK_W-1:0] rd_last;
   logic [CNT_W-1:0]  rd_uses;
   logic              do_fill;
   logic              do_hit;
   logic              sel_ok;
   logic              do_use;
   logic              do_rel;
   logic              tick_adv;
   logic [TICK_W-1:0] tick_next;
   logic [REF_W-1:0]  ref_new;
   logic [CNT_W-1:0]  uses_new;
   logic [STATUS_W-1:0] status_new;
   logic [SEL_W-1:0]  slot_new;
   logic [KIND_W-1:0] kind_new;
   logic [CNT_W-1:0]  uses_out;

   // Capture the request on acceptance
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         key_ff  <= req_key_present;
         tag_ff  <= req_key_tag;
         kind_ff <= req_kind_code;
         sel_ff  <= req_slot_select;
      end
   end

   // Compare the tag in every slot and find the first match and first free slot
   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         match_vec[i] = occ_ff[i] && (etag_ff[i] == tag_ff);
         if (match_vec[i]) match_idx = SLOT_W'(i);
         if (!occ_ff[i]) free_idx = SLOT_W'(i);
      end
   end

   assign is_acq    = (op_ff == OP_ACQUIRE);
   assign is_sel_op = (op_ff == OP_USE) || (op_ff == OP_RELEASE);
   assign in_range  = {1'b0, sel_ff} < (SEL_W + 1)'(SLOTS);

   assign sts.need_scan = is_acq && key_ff && !(|match_vec) && (&occ_ff);
   assign sts.scan_last = (scan_idx_ff == SLOT_W'(SLOTS - 1));

   // Hold the lookup results for the update
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         hit_ff      <= |match_vec;
         hit_idx_ff  <= match_idx;
         free_any_ff <= !(&occ_ff);
         free_idx_ff <= free_idx;
      end
   end

   // Pick the slot that the update touches
   always_comb begin
      if (is_acq) begin
         if (hit_ff) target = hit_idx_ff;
         else if (free_any_ff) target = free_idx_ff;
         else target = best_idx_ff;
      end else begin
         target = in_range ? sel_ff[SLOT_W-1:0] : '0;
      end
   end

   // Share one read port between the scan and the update
   assign rd_idx  = cmd.scan ? scan_idx_ff : target;
   assign rd_occ  = occ_ff[rd_idx];
   assign rd_kind = ekind_ff[rd_idx];
   assign rd_ref  = eref_ff[rd_idx];
   assign rd_last = elast_ff[rd_idx];
   assign rd_uses = euses_ff[rd_idx];

   // Walk the slots for the oldest unreferenced one, slot 0 as starting candidate
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         if (scan_idx_ff == '0) begin
            best_idx_ff  <= '0;
            best_tick_ff <= rd_last;
         end else if ((rd_ref == '0) && (rd_last < best_tick_ff)) begin
            best_idx_ff  <= scan_idx_ff;
            best_tick_ff <= rd_last;
         end
      end
   end

   // Work out the effect of the request on the target slot
   always_comb begin
      do_fill   = is_acq && key_ff && !hit_ff;
      do_hit    = is_acq && key_ff && hit_ff;
      sel_ok    = is_sel_op && in_range && rd_occ;
      do_use    = sel_ok && (op_ff == OP_USE);
      do_rel    = sel_ok && (op_ff == OP_RELEASE) && (rd_ref != '0);
      tick_adv  = (is_acq && key_ff) || do_use || do_rel;
      tick_next = tick_ff + 1'b1;

      if (do_fill) ref_new = REF_W'(1);
      else if (do_hit) ref_new = rd_ref + 1'b1;
      else ref_new = rd_ref - 1'b1;

      uses_new = do_fill ? '0 : rd_uses + 1'b1;

      if (is_acq && !key_ff) status_new = ST_NO_KEY;
      else if (is_sel_op && !in_range) status_new = ST_RANGE;
      else if (is_sel_op && !rd_occ) status_new = ST_EMPTY;
      else status_new = ST_OK;

      if (is_acq) slot_new = key_ff ? SEL_W'(target) : '0;
      else slot_new = sel_ff;

      if (do_fill) kind_new = kind_ff;
      else if (do_hit || sel_ok) kind_new = rd_kind;
      else kind_new = '0;

      if (do_use) uses_out = uses_new;
      else if (do_hit || sel_ok) uses_out = rd_uses;
      else uses_out = '0;
   end

   // Write the target slot
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         if (do_fill) begin
            etag_ff[target]  <= tag_ff;
            ekind_ff[target] <= kind_ff;
         end
         if (do_fill || do_hit || do_rel) eref_ff[target] <= ref_new;
         if (do_fill || do_use) euses_ff[target] <= uses_new;
         if (tick_adv) elast_ff[target] <= tick_next;
      end
   end

   // Keep occupancy and the global counters
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         tick_ff   <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
      end else if (cmd.update) begin
         if (do_fill) occ_ff[target] <= 1'b1;
         if (tick_adv) tick_ff <= tick_next;
         if (do_hit) hits_ff <= hits_ff + 1'b1;
         if (do_fill) misses_ff <= misses_ff + 1'b1;
      end
   end

   // Register the response and strobe it for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_status      <= status_new;
         rsp_slot_number <= slot_new;
         rsp_hit         <= do_hit;
         rsp_slot_kind   <= kind_new;
         rsp_slot_uses   <= uses_out;
         rsp_hit_total   <= do_hit ? hits_ff + 1'b1 : hits_ff;
         rsp_miss_total  <= do_fill ? misses_ff + 1'b1 : misses_ff;
      end
   end

endmodule

### design/refcounted_lru_slot_cache.sv
// Top level of the reference counted slot cache with LRU replacement.
//
// Usage:
//   Present a request on the req_ ports with start high; it is taken at a
//   clock edge where start is high and busy is low. Busy stays high while
//   the request is worked on, and the next request is taken once it drops.
//   One response per request appears on the rsp_ ports for exactly one
//   cycle, marked by rsp_valid; the receiver has no way to hold it off.
//   The request passes through the decode and update states, and the response
//   strobe is registered from the update state. An acquire that misses while
//   every slot is occupied first runs the victim search, which walks the slot
//   table one entry per cycle over the table's single read port. A new request
//   may be accepted in the cycle the response is shown.
//   Reset clears all slots to unoccupied and zeroes the global tick and the
//   hit and miss totals.
`timescale 1ns / 1ps
module refcounted_lru_slot_cache
   import rlsc_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic                req_key_present,
   input  logic [TAG_W-1:0]    req_key_tag,
   input  logic [KIND_W-1:0]   req_kind_code,
   input  logic [SEL_W-1:0]    req_slot_select,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SEL_W-1:0]    rsp_slot_number,
   output logic                rsp_hit,
   output logic [KIND_W-1:0]   rsp_slot_kind,
   output logic [CNT_W-1:0]    rsp_slot_uses,
   output logic [CNT_W-1:0]    rsp_hit_total,
   output logic [CNT_W-1:0]    rsp_miss_total
);

   rlsc_cmd_type cmd;
   rlsc_sts_type sts;

   rlsc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   rlsc_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_opcode),
      .req_key_present (req_key_present),
      .req_key_tag     (req_key_tag),
      .req_kind_code   (req_kind_code),
      .req_slot_select (req_slot_select),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot_number (rsp_slot_number),
      .rsp_hit         (rsp_hit),
      .rsp_slot_kind   (rsp_slot_kind),
      .rsp_slot_uses   (rsp_slot_uses),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_miss_total  (rsp_miss_total)
   );

endmodule

### design/rlsc_checker.sv
// Port level checks of the slot cache and their binding to the top level.
`timescale 1ns / 1ps
`include "refcounted_lru_slot_cache_macros.svh"
module rlsc_checker
   import rlsc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [SEL_W-1:0]    rsp_slot_number,
   input logic                rsp_hit,
   input logic [CNT_W-1:0]    rsp_slot_uses
);

   // An accepted request keeps the block busy in the next cycle
   `RLSC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")

   // The response comes out only once the work on it is over
   `RLSC_ASSERT_SAME(a_rsp_idle, rsp_valid, !busy, "response strobe while busy")

   // The strobe lasts a single cycle
   `RLSC_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "response strobe held over")

   // A missing key reports slot zero, no hit and no uses
   `RLSC_ASSERT_SAME(a_no_key_form, rsp_valid && (rsp_status == ST_NO_KEY), (rsp_slot_number == '0) && !rsp_hit && (rsp_slot_uses == '0), "malformed missing key response")

endmodule

bind refcounted_lru_slot_cache rlsc_checker u_checker (.*);
